// ----- rtl/ict_pkg.sv -----
// Shared types and constants for the ink coverage and supply tracker.
`timescale 1ns / 1ps
`default_nettype none

package ict_pkg;

    localparam int NCOL    = 4;
    localparam int AMT_W   = 11;   // largest pixel amount is 8 * 255
    localparam int LEVEL_W = 7;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int CFG_W   = 16;
    localparam int AREA_W  = 32;
    localparam int DIV_W   = AREA_W + 5;   // area times 20

    // Input action codes
    localparam logic [1:0] ACT_PIXEL = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    // Color modes
    localparam logic [2:0] MODE_BLACK1 = 3'd0;
    localparam logic [2:0] MODE_BLACK8 = 3'd1;
    localparam logic [2:0] MODE_GRAY   = 3'd2;
    localparam logic [2:0] MODE_RGB    = 3'd3;
    localparam logic [2:0] MODE_CMYK   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLOR_MODE  = 2'd0;
    localparam logic [1:0] CFG_PAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_PAGE_HEIGHT = 2'd2;

    localparam logic [2:0]  COLOR_MODE_RST  = MODE_RGB;
    localparam logic [15:0] PAGE_WIDTH_RST  = 16'd2550;
    localparam logic [15:0] PAGE_HEIGHT_RST = 16'd3300;

    localparam logic [LEVEL_W-1:0] PCT_FULL   = 7'd100;
    localparam logic [LEVEL_W-1:0] PCT_LOW    = 7'd10;
    localparam logic [LEVEL_W-1:0] PCT_ALMOST = 7'd90;

    // Index of the waste figure in the division sequence
    localparam logic [2:0] IDX_WASTE = 3'd4;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_START,
        OP_END
    } t_op;

    typedef struct packed {
        t_op                         op;
        logic [NCOL-1:0][AMT_W-1:0]  amt;   // cyan in lane 0, black in lane 3
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_TOTAL,
        BS_AREA,
        BS_SCALE,
        BS_LOAD,
        BS_DIV,
        BS_APPLY,
        BS_REPORT
    } t_bstate;

endpackage

`default_nettype wire

// ----- rtl/ict_front.sv -----
// Front end: takes input items and turns pixels into per-colorant ink amounts.
`timescale 1ns / 1ps
`default_nettype none

module ict_front (
    input  wire logic              i_valid,
    input  wire logic [1:0]        i_action,
    input  wire logic [31:0]       i_bytes,
    input  wire logic [2:0]        i_color_mode,
    input  wire ict_pkg::t_qstat   i_qstat,
    output logic                   o_ready,
    output logic                   o_push,
    output ict_pkg::t_qent         o_entry
);

    logic [7:0]                 b0, b1, b2, b3;
    logic [7:0]                 c, m, y, k;
    logic [3:0]                 ones;
    logic [ict_pkg::AMT_W:0]    black1;
    logic                       keep;
    logic [ict_pkg::AMT_W-1:0]  a0, a1, a2, a3;

    assign b0 = i_bytes[7:0];
    assign b1 = i_bytes[15:8];
    assign b2 = i_bytes[23:16];
    assign b3 = i_bytes[31:24];

    assign c = 8'd255 - b0;
    assign m = 8'd255 - b1;
    assign y = 8'd255 - b2;

    always_comb begin
        k = c;
        if (k > m) k = m;
        if (k > y) k = y;
    end

    always_comb begin
        ones = '0;
        for (int i = 0; i < 8; i++) begin
            ones = ones + {3'd0, b0[i]};
        end
    end

    // Each set bit counts 255: ones * 256 - ones.
    assign black1 = {ones, 8'd0} - {8'd0, ones};

    always_comb begin
        a0   = '0;
        a1   = '0;
        a2   = '0;
        a3   = '0;
        keep = 1'b1;
        unique case (i_color_mode)
            ict_pkg::MODE_BLACK1: begin
                a3 = black1[ict_pkg::AMT_W-1:0];
            end
            ict_pkg::MODE_BLACK8: a3 = {3'd0, b0};
            ict_pkg::MODE_GRAY:   a3 = {3'd0, c};
            ict_pkg::MODE_RGB: begin
                a0 = {3'd0, c - k};
                a1 = {3'd0, m - k};
                a2 = {3'd0, y - k};
                a3 = {3'd0, k};
            end
            ict_pkg::MODE_CMYK: begin
                a0 = {3'd0, b0};
                a1 = {3'd0, b1};
                a2 = {3'd0, b2};
                a3 = {3'd0, b3};
            end
            default: keep = 1'b0;
        endcase
    end

    always_comb begin
        o_entry.amt = {a3, a2, a1, a0};
        o_entry.op  = ict_pkg::OP_PIXEL;
        o_push      = 1'b0;
        unique case (i_action)
            ict_pkg::ACT_PIXEL: begin
                o_entry.op = ict_pkg::OP_PIXEL;
                o_push     = keep;
            end
            ict_pkg::ACT_START: begin
                o_entry.op = ict_pkg::OP_START;
                o_push     = 1'b1;
            end
            ict_pkg::ACT_END: begin
                o_entry.op = ict_pkg::OP_END;
                o_push     = 1'b1;
            end
            default: o_push = 1'b0;
        endcase
        o_push = o_push & i_valid & o_ready;
    end

    // Items that leave no trace (unused action, non-counting mode) are still taken.
    assign o_ready = !i_qstat.full;

endmodule

`default_nettype wire

// ----- rtl/ict_fifo.sv -----
// Short queue of classified requests between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module ict_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ict_pkg::t_qent    i_entry,
    input  wire logic              i_pop,
    output ict_pkg::t_qent         o_entry,
    output ict_pkg::t_qstat        o_qstat
);

    ict_pkg::t_qent                r_mem [ict_pkg::QDEPTH];
    logic [ict_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [ict_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [ict_pkg::QPTR_W:0]      r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + {{(ict_pkg::QPTR_W - 1){1'b0}}, i_push};
        n_rd_ptr = r_rd_ptr + {{(ict_pkg::QPTR_W - 1){1'b0}}, i_pop};
        n_count  = r_count + {{ict_pkg::QPTR_W{1'b0}}, i_push}
                           - {{ict_pkg::QPTR_W{1'b0}}, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry       = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == (ict_pkg::QPTR_W + 1)'(ict_pkg::QDEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

`default_nettype wire

// ----- rtl/ict_back.sv -----
// Back end: coverage sums, end-of-page division sequence and level update.
`timescale 1ns / 1ps
`default_nettype none

module ict_back #(
    parameter int SUM_BITS = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [15:0]       i_page_width,
    input  wire logic [15:0]       i_page_height,
    input  wire ict_pkg::t_qent    i_entry,
    input  wire ict_pkg::t_qstat   i_qstat,
    output logic                   o_pop,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [39:0]            o_out_data
);

    // Width of the total and of every dividend, capped at 64 bits; the total saturates.
    localparam int DW = (SUM_BITS + 2 > 64) ? 64 : SUM_BITS + 2;
    localparam int CW = $clog2(DW + 1);
    localparam int LW = ict_pkg::LEVEL_W;
    localparam int NC = ict_pkg::NCOL;

    ict_pkg::t_bstate                r_state, n_state;
    logic [SUM_BITS-1:0]             r_sum [NC];
    logic [SUM_BITS-1:0]             n_sum [NC];
    logic [LW-1:0]                   r_level [NC];
    logic [LW-1:0]                   n_level [NC];
    logic [LW-1:0]                   r_waste, n_waste;
    logic [DW-1:0]                   r_total, n_total;
    logic [2:0]                      r_idx, n_idx;
    logic [ict_pkg::AREA_W-1:0]      r_area, n_area;
    logic [ict_pkg::DIV_W-3:0]       r_div5, n_div5;
    logic [DW-1:0]                   r_dvd, n_dvd;
    logic [ict_pkg::DIV_W-1:0]       r_rem, n_rem;
    logic [DW-1:0]                   r_quo, n_quo;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic                            r_out_valid, n_out_valid;
    logic [39:0]                     r_out_data, n_out_data;

    logic [15:0]                     w_eff, h_eff;
    logic [ict_pkg::DIV_W-1:0]       divisor;
    logic [ict_pkg::DIV_W:0]         rem_sh, rem_diff;
    logic [DW:0]                     tot_add;
    logic                            out_free;
    logic                            any_empty, any_low;

    assign w_eff    = (i_page_width == '0) ? 16'd1 : i_page_width;
    assign h_eff    = (i_page_height == '0) ? 16'd1 : i_page_height;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = (r_state == ict_pkg::BS_IDLE) && !i_qstat.empty;

    // Divisor is area * 5 for cyan, magenta, yellow; * 10 for black; * 20 for waste.
    always_comb begin
        if (r_idx == ict_pkg::IDX_WASTE) begin
            divisor = {r_div5, 2'b00};
        end else if (r_idx == 3'd3) begin
            divisor = {1'b0, r_div5, 1'b0};
        end else begin
            divisor = {2'b00, r_div5};
        end
    end

    assign rem_sh   = {r_rem, r_dvd[DW-1]};
    assign rem_diff = rem_sh - {1'b0, divisor};
    assign tot_add  = {1'b0, r_total} + (DW + 1)'(r_sum[r_idx[1:0]]);

    always_comb begin
        any_empty = 1'b0;
        any_low   = 1'b0;
        for (int i = 0; i < NC; i++) begin
            if (r_level[i] == '0) begin
                any_empty = 1'b1;
            end else if (r_level[i] < ict_pkg::PCT_LOW) begin
                any_low = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ict_pkg::BS_IDLE: begin
                if (!i_qstat.empty && i_entry.op == ict_pkg::OP_END) begin
                    n_state = ict_pkg::BS_TOTAL;
                end
            end
            ict_pkg::BS_TOTAL: begin
                if (r_idx == 3'd3) n_state = ict_pkg::BS_AREA;
            end
            ict_pkg::BS_AREA:  n_state = ict_pkg::BS_SCALE;
            ict_pkg::BS_SCALE: n_state = ict_pkg::BS_LOAD;
            ict_pkg::BS_LOAD:  n_state = ict_pkg::BS_DIV;
            ict_pkg::BS_DIV: begin
                if (r_cnt == CW'(1)) n_state = ict_pkg::BS_APPLY;
            end
            ict_pkg::BS_APPLY: begin
                if (r_idx == ict_pkg::IDX_WASTE) begin
                    n_state = ict_pkg::BS_REPORT;
                end else begin
                    n_state = ict_pkg::BS_LOAD;
                end
            end
            ict_pkg::BS_REPORT: begin
                if (out_free) n_state = ict_pkg::BS_IDLE;
            end
            default: n_state = ict_pkg::BS_IDLE;
        endcase
    end

    // Datapath updates per state
    always_comb begin
        logic [SUM_BITS:0] acc;
        n_sum       = r_sum;
        n_level     = r_level;
        n_waste     = r_waste;
        n_total     = r_total;
        n_idx       = r_idx;
        n_area      = r_area;
        n_div5      = r_div5;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_out_ready;
        acc         = '0;
        unique case (r_state)
            ict_pkg::BS_IDLE: begin
                if (!i_qstat.empty) begin
                    unique case (i_entry.op)
                        ict_pkg::OP_PIXEL: begin
                            for (int i = 0; i < NC; i++) begin
                                acc = {1'b0, r_sum[i]} + (SUM_BITS + 1)'(i_entry.amt[i]);
                                n_sum[i] = acc[SUM_BITS] ? '1 : acc[SUM_BITS-1:0];
                            end
                        end
                        ict_pkg::OP_START: begin
                            for (int i = 0; i < NC; i++) n_sum[i] = '0;
                        end
                        ict_pkg::OP_END: begin
                            n_total = '0;
                            n_idx   = '0;
                        end
                        default: n_idx = r_idx;
                    endcase
                end
            end
            ict_pkg::BS_TOTAL: begin
                n_total = tot_add[DW] ? '1 : tot_add[DW-1:0];
                n_idx   = (r_idx == 3'd3) ? 3'd0 : r_idx + 3'd1;
            end
            ict_pkg::BS_AREA: begin
                n_area = {16'd0, w_eff} * {16'd0, h_eff};
            end
            ict_pkg::BS_SCALE: begin
                n_div5 = {1'b0, r_area, 2'b00} + {3'd0, r_area};
            end
            ict_pkg::BS_LOAD: begin
                n_dvd = (r_idx == ict_pkg::IDX_WASTE) ? r_total : DW'(r_sum[r_idx[1:0]]);
                n_rem = '0;
                n_quo = '0;
                n_cnt = CW'(DW);
            end
            ict_pkg::BS_DIV: begin
                // one quotient bit per cycle, restoring division
                if (!rem_diff[ict_pkg::DIV_W]) begin
                    n_rem = rem_diff[ict_pkg::DIV_W-1:0];
                    n_quo = {r_quo[DW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[ict_pkg::DIV_W-1:0];
                    n_quo = {r_quo[DW-2:0], 1'b0};
                end
                n_dvd = {r_dvd[DW-2:0], 1'b0};
                n_cnt = r_cnt - CW'(1);
            end
            ict_pkg::BS_APPLY: begin
                if (r_idx == ict_pkg::IDX_WASTE) begin
                    if (r_quo > DW'(ict_pkg::PCT_FULL - r_waste)) begin
                        n_waste = '0;
                    end else begin
                        n_waste = r_waste + r_quo[LW-1:0];
                    end
                end else begin
                    if (r_quo > DW'(r_level[r_idx[1:0]])) begin
                        n_level[r_idx[1:0]] = ict_pkg::PCT_FULL;
                    end else begin
                        n_level[r_idx[1:0]] = r_level[r_idx[1:0]] - r_quo[LW-1:0];
                    end
                    n_idx = r_idx + 3'd1;
                end
            end
            ict_pkg::BS_REPORT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0,
                                   (r_waste != ict_pkg::PCT_FULL) &&
                                       (r_waste >= ict_pkg::PCT_ALMOST),
                                   r_waste == ict_pkg::PCT_FULL,
                                   any_low, any_empty, r_waste,
                                   r_level[3], r_level[2], r_level[1], r_level[0]};
                end
            end
            default: n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ict_pkg::BS_IDLE;
            r_out_valid <= 1'b0;
            r_waste     <= '0;
            r_idx       <= '0;
            for (int i = 0; i < NC; i++) begin
                r_sum[i]   <= '0;
                r_level[i] <= ict_pkg::PCT_FULL;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_waste     <= n_waste;
            r_idx       <= n_idx;
            r_sum       <= n_sum;
            r_level     <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total    <= n_total;
        r_area     <= n_area;
        r_div5     <= n_div5;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- rtl/ink_coverage_supply_tracker.sv -----
// Top level of the ink coverage and supply tracker.
//
//  Channel   Direction  Accepted when               Contents
//  s_axis    in         tvalid && tready            tuser: action; tdata: four pixel bytes
//  m_axis    out        tvalid && tready            tdata: five levels and four status flags
//  cfg       in         i_cfg_we                    index 0 mode, 1 width, 2 height
//
// Pixel and start-of-page requests are taken one per cycle while the queue has room and
// drain one per cycle while the back end is idle. An end-of-page request runs the total,
// area and scaling steps, then the one-bit-per-cycle divider five times in a row. A
// four-entry queue keeps taking requests during that sequence until it fills.
// Reset is synchronous and active low; sums clear, ink levels go to 100, waste to 0.
// A finished result waits in the output register without stopping the front end.
`timescale 1ns / 1ps
`default_nettype none

module ink_coverage_supply_tracker #(
    parameter int SUM_BITS = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [31:0]   i_s_axis_tdata,   // pixel_byte0..pixel_byte3, low bits first
    input  wire logic [1:0]    i_s_axis_tuser,   // action
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // cyan_level, magenta_level, yellow_level, black_level, waste_level, supply_empty,
    // supply_low, waste_full, waste_almost_full, then one zero pad bit
    output logic [39:0]        o_m_axis_tdata,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_addr,
    input  wire logic [15:0]   i_cfg_wdata
);

    logic [2:0]          r_color_mode;
    logic [15:0]         r_page_width;
    logic [15:0]         r_page_height;

    ict_pkg::t_qent      push_entry, pop_entry;
    ict_pkg::t_qstat     qstat;
    logic                push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode  <= ict_pkg::COLOR_MODE_RST;
            r_page_width  <= ict_pkg::PAGE_WIDTH_RST;
            r_page_height <= ict_pkg::PAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ict_pkg::CFG_COLOR_MODE:  r_color_mode  <= i_cfg_wdata[2:0];
                ict_pkg::CFG_PAGE_WIDTH:  r_page_width  <= i_cfg_wdata;
                ict_pkg::CFG_PAGE_HEIGHT: r_page_height <= i_cfg_wdata;
                default: r_color_mode <= r_color_mode;
            endcase
        end
    end

    ict_front u_front (
        .i_valid      (i_s_axis_tvalid),
        .i_action     (i_s_axis_tuser),
        .i_bytes      (i_s_axis_tdata),
        .i_color_mode (r_color_mode),
        .i_qstat      (qstat),
        .o_ready      (o_s_axis_tready),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    ict_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_qstat (qstat)
    );

    ict_back #(
        .SUM_BITS (SUM_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_page_width  (r_page_width),
        .i_page_height (r_page_height),
        .i_entry       (pop_entry),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_data    (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
